// ----- design/dtse_pkg.sv -----
// shared types, codes and calendar helpers for the date/time set editor
package dtse_pkg;

    localparam int unsigned YEAR_W   = 12;
    localparam int unsigned MONTH_W  = 4;
    localparam int unsigned DAY_W    = 5;
    localparam int unsigned LDAY_W   = 7;
    localparam int unsigned HOUR_W   = 5;
    localparam int unsigned MINUTE_W = 6;
    localparam int unsigned FOCUS_W  = 3;
    localparam int unsigned CMD_W    = 3;

    localparam logic [YEAR_W-1:0] YEAR_LOW_RST  = 12'd2020;
    localparam logic [YEAR_W-1:0] YEAR_HIGH_RST = 12'd2040;

    localparam logic [HOUR_W-1:0]   HOUR_LOAD  = 5'd9;
    localparam logic [HOUR_W-1:0]   HOUR_MAX   = 5'd23;
    localparam logic [MINUTE_W-1:0] MINUTE_MAX = 6'd55;
    localparam logic [MINUTE_W-1:0] MINUTE_STEP = 6'd5;

    // configuration register indexes
    localparam logic REG_YEAR_LOW  = 1'b0;
    localparam logic REG_YEAR_HIGH = 1'b1;

    typedef enum logic [CMD_W-1:0] {
        CMD_UP     = 3'd0,
        CMD_DOWN   = 3'd1,
        CMD_SELECT = 3'd2,
        CMD_BACK   = 3'd3,
        CMD_LOAD   = 3'd4
    } t_cmd;

    localparam logic [FOCUS_W-1:0] FOCUS_MONTH  = 3'd0;
    localparam logic [FOCUS_W-1:0] FOCUS_DAY    = 3'd1;
    localparam logic [FOCUS_W-1:0] FOCUS_YEAR   = 3'd2;
    localparam logic [FOCUS_W-1:0] FOCUS_HOUR   = 3'd3;
    localparam logic [FOCUS_W-1:0] FOCUS_MINUTE = 3'd4;

    localparam logic [DAY_W-1:0] MONTH_LEN [12] = '{
        5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
        5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
    };

    typedef struct packed {
        logic [CMD_W-1:0]   command;
        logic [YEAR_W-1:0]  load_year;
        logic [MONTH_W-1:0] load_month;
        logic [LDAY_W-1:0]  load_day;
    } t_in_item;

    typedef struct packed {
        logic [MONTH_W-1:0]  month;
        logic [DAY_W-1:0]    day;
        logic [YEAR_W-1:0]   year;
        logic [HOUR_W-1:0]   hour;
        logic [MINUTE_W-1:0] minute;
        logic [FOCUS_W-1:0]  focus;
        logic                commit;
        logic                cancel;
    } t_out_item;

    typedef struct packed {
        logic [MONTH_W-1:0]  month;
        logic [DAY_W-1:0]    day;
        logic [YEAR_W-1:0]   year;
        logic [HOUR_W-1:0]   hour;
        logic [MINUTE_W-1:0] minute;
        logic [FOCUS_W-1:0]  focus;
    } t_edit_state;

    // gregorian rule; multiple of 25 found by reciprocal multiply (2^17/25)
    function automatic logic f_leap(input logic [YEAR_W-1:0] y);
        logic [24:0]       prod;
        logic [7:0]        q;
        logic [YEAR_W-1:0] q25;
        logic              div25;
        prod  = {13'd0, y} * 25'd5243;
        q     = prod[24:17];
        q25   = ({4'd0, q} << 4) + ({4'd0, q} << 3) + {4'd0, q};
        div25 = (q25 == y);
        return ((y[1:0] == 2'd0) && !div25) || (y[3:0] == 4'd0);
    endfunction

    function automatic logic [DAY_W-1:0] f_month_days(input logic [MONTH_W-1:0] m,
                                                      input logic leap);
        logic [DAY_W-1:0] len;
        if (m < 4'd1 || m > 4'd12) begin
            len = 5'd31;
        end else if (m == 4'd2 && leap) begin
            len = 5'd29;
        end else begin
            len = MONTH_LEN[m - 4'd1];
        end
        return len;
    endfunction

endpackage

// ----- design/date_time_set_editor_core.sv -----
// top level of the date/time set editor: handshakes, state and registers
//
// Input channel: i_in_valid / o_in_stall with one command per transfer in
// i_in_data (up, down, select, back, load date). Output channel:
// o_out_valid / i_out_stall; every command yields exactly one result holding
// the date, time and focus after the command plus commit and cancel flags.
// Configuration: i_cfg_we with i_cfg_index (0 lowest year, 1 highest year)
// and i_cfg_data; write only while no command is in flight.
// An accepted command waits in the input register while the update logic
// works on it; the result is then registered in the output register, which
// a stalled result ahead of it can hold off.
// Throughput: one command per cycle unless stalled; edit state is rewritten in
// the same cycle a result is registered, so the next command sees it at once.
// Reset (synchronous, active low) sets 1/1/2020 09:00, focus on the month,
// year range 2020..2040, and empties both registers.
// A stalled result holds; the input register still takes one more command,
// after which o_in_stall rises until the output drains.
module date_time_set_editor_core
    import dtse_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  t_in_item            i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output t_out_item           o_out_data,
    input  logic                i_cfg_we,
    input  logic                i_cfg_index,
    input  logic [YEAR_W-1:0]   i_cfg_data
);

    logic              r_in_valid;
    t_in_item          r_in;
    logic              r_out_valid;
    t_out_item         r_out;
    t_edit_state       r_state;
    logic [YEAR_W-1:0] r_year_low;
    logic [YEAR_W-1:0] r_year_high;

    logic              n_in_valid;
    logic              n_out_valid;
    t_out_item         n_out;
    t_edit_state       n_state;
    logic              adv;
    logic              take;
    logic              upd_commit;
    logic              upd_cancel;

    dtse_update u_update (
        .i_state     (r_state),
        .i_item      (r_in),
        .i_year_low  (r_year_low),
        .i_year_high (r_year_high),
        .o_state     (n_state),
        .o_commit    (upd_commit),
        .o_cancel    (upd_cancel)
    );

    assign adv        = r_in_valid && (!r_out_valid || !i_out_stall);
    assign take       = i_in_valid && !o_in_stall;
    assign o_in_stall = r_in_valid && !adv;

    always_comb begin
        n_in_valid  = take ? 1'b1 : (adv ? 1'b0 : r_in_valid);
        n_out_valid = adv ? 1'b1 : (r_out_valid && i_out_stall);
        n_out = '{month:  n_state.month,  day:    n_state.day,
                  year:   n_state.year,   hour:   n_state.hour,
                  minute: n_state.minute, focus:  n_state.focus,
                  commit: upd_commit,     cancel: upd_cancel};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_state     <= '{month: 4'd1, day: 5'd1, year: YEAR_LOW_RST,
                             hour: HOUR_LOAD, minute: 6'd0, focus: FOCUS_MONTH};
            r_year_low  <= YEAR_LOW_RST;
            r_year_high <= YEAR_HIGH_RST;
        end else begin
            r_in_valid  <= n_in_valid;
            r_out_valid <= n_out_valid;
            if (adv) begin
                r_state <= n_state;
            end
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_YEAR_LOW:  r_year_low  <= i_cfg_data;
                    REG_YEAR_HIGH: r_year_high <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (take) begin
            r_in <= i_in_data;
        end
        if (adv) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    a_focus_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.focus <= FOCUS_MINUTE)
        else $error("focus left the field range");

    a_day_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.day != 5'd0 && r_state.day <= 5'd31)
        else $error("day out of range");

    a_time_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.hour <= HOUR_MAX && r_state.minute <= MINUTE_MAX)
        else $error("time out of range");

    a_flags_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_out_data.commit && o_out_data.cancel))
        else $error("commit and cancel together");

    a_state_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_out_stall) |=> $stable(r_state))
        else $error("state changed while result stalled");

endmodule

// ----- design/dtse_update.sv -----
// next-state logic of the editor for one command
module dtse_update
    import dtse_pkg::*;
(
    input  t_edit_state         i_state,
    input  t_in_item            i_item,
    input  logic [YEAR_W-1:0]   i_year_low,
    input  logic [YEAR_W-1:0]   i_year_high,
    output t_edit_state         o_state,
    output logic                o_commit,
    output logic                o_cancel
);

    logic [YEAR_W-1:0]   hi;
    logic                leap_cur;
    logic [DAY_W-1:0]    dim_cur;
    logic [YEAR_W-1:0]   y_cand;
    logic [MONTH_W-1:0]  m_cand;
    logic [LDAY_W-1:0]   d_pre;
    logic                fit;
    logic                leap_nxt;
    logic [DAY_W-1:0]    dim_nxt;
    logic [DAY_W-1:0]    d_max;
    logic                dn;
    logic signed [13:0]  yv;
    logic [YEAR_W-1:0]   y_clamp;
    logic [YEAR_W-1:0]   ly_clamp;
    logic [6:0]          min_sum;
    t_edit_state         base;

    assign hi       = (i_year_high < i_year_low) ? i_year_low : i_year_high;
    assign leap_cur = f_leap(i_state.year);
    assign dim_cur  = f_month_days(i_state.month, leap_cur);
    assign dn       = (i_item.command == CMD_DOWN);

    // stored year and load year clamped into range, for commit and load
    always_comb begin
        y_clamp = i_state.year;
        if (y_clamp < i_year_low) y_clamp = i_year_low;
        if (y_clamp > hi) y_clamp = hi;
        ly_clamp = i_item.load_year;
        if (ly_clamp < i_year_low) ly_clamp = i_year_low;
        if (ly_clamp > hi) ly_clamp = hi;
    end

    always_comb begin
        yv      = dn ? ($signed({2'b00, i_state.year}) - 14'sd1)
                     : ($signed({2'b00, i_state.year}) + 14'sd1);
        min_sum = {1'b0, i_state.minute} + {1'b0, MINUTE_STEP};
    end

    always_comb begin
        base     = i_state;
        o_commit = 1'b0;
        o_cancel = 1'b0;
        y_cand   = i_state.year;
        m_cand   = i_state.month;
        d_pre    = {2'b00, i_state.day};
        fit      = 1'b0;
        case (t_cmd'(i_item.command))
            CMD_UP, CMD_DOWN: begin
                case (i_state.focus)
                    FOCUS_MONTH: begin
                        if (dn) begin
                            m_cand = (i_state.month <= 4'd1) ? 4'd12 : i_state.month - 4'd1;
                        end else begin
                            m_cand = (i_state.month >= 4'd12) ? 4'd1 : i_state.month + 4'd1;
                        end
                        fit = 1'b1;
                    end
                    FOCUS_DAY: begin
                        if (dn) begin
                            base.day = (i_state.day <= 5'd1) ? dim_cur
                                                             : i_state.day - 5'd1;
                        end else begin
                            base.day = ({1'b0, i_state.day} + 6'd1 > {1'b0, dim_cur})
                                     ? 5'd1 : i_state.day + 5'd1;
                        end
                    end
                    FOCUS_YEAR: begin
                        if (yv > $signed({2'b00, hi})) begin
                            y_cand = i_year_low;
                        end else if (yv < $signed({2'b00, i_year_low})) begin
                            y_cand = hi;
                        end else begin
                            y_cand = yv[YEAR_W-1:0];
                        end
                        fit = 1'b1;
                    end
                    FOCUS_HOUR: begin
                        if (dn) begin
                            base.hour = (i_state.hour == 5'd0) ? HOUR_MAX
                                                               : i_state.hour - 5'd1;
                        end else begin
                            base.hour = (i_state.hour >= HOUR_MAX) ? 5'd0
                                                                   : i_state.hour + 5'd1;
                        end
                    end
                    default: begin
                        if (dn) begin
                            base.minute = (i_state.minute < MINUTE_STEP) ? MINUTE_MAX
                                        : i_state.minute - MINUTE_STEP;
                        end else begin
                            base.minute = (min_sum > {1'b0, MINUTE_MAX}) ? 6'd0
                                        : min_sum[MINUTE_W-1:0];
                        end
                    end
                endcase
            end
            CMD_SELECT: begin
                if (i_state.focus < FOCUS_MINUTE) begin
                    base.focus = i_state.focus + 3'd1;
                end else begin
                    o_commit = 1'b1;
                    y_cand   = y_clamp;
                    fit      = 1'b1;
                end
            end
            CMD_BACK: begin
                if (i_state.focus > FOCUS_MONTH) begin
                    base.focus = i_state.focus - 3'd1;
                end else begin
                    o_cancel = 1'b1;
                end
            end
            CMD_LOAD: begin
                y_cand = ly_clamp;
                if (i_item.load_month < 4'd1) begin
                    m_cand = 4'd1;
                end else if (i_item.load_month > 4'd12) begin
                    m_cand = 4'd12;
                end else begin
                    m_cand = i_item.load_month;
                end
                d_pre       = i_item.load_day;
                fit         = 1'b1;
                base.hour   = HOUR_LOAD;
                base.minute = '0;
                base.focus  = FOCUS_MONTH;
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        o_state       = base;
        o_state.year  = y_cand;
        o_state.month = m_cand;
        if (fit) begin
            if (d_pre > {2'b00, d_max}) begin
                o_state.day = d_max;
            end else if (d_pre < 7'd1) begin
                o_state.day = 5'd1;
            end else begin
                o_state.day = d_pre[DAY_W-1:0];
            end
        end
    end

    assign leap_nxt = f_leap(y_cand);
    assign dim_nxt  = f_month_days(m_cand, leap_nxt);
    // commit clamps against the old and the new month length in turn
    assign d_max    = (o_commit && dim_cur < dim_nxt) ? dim_cur : dim_nxt;

endmodule
